>>> rtl/core/fts_pkg.sv
// shared types, constants and the helper function of the fibonacci table search
`default_nettype none
package fts_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int VALUE_WIDTH = 32;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int FIB_N       = 32;
	localparam int FIB_IDX_W   = $clog2(FIB_N);

	typedef logic signed [VALUE_WIDTH-1:0] value_t;
	typedef logic [ADDR_W-1:0]             addr_t;
	typedef logic [CNT_W-1:0]              count_t;
	typedef logic [FIB_IDX_W-1:0]          fib_idx_t;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	// fibonacci numbers F(0) .. F(31)
	localparam logic [31:0] FIB_TAB [FIB_N] = '{
		32'd0, 32'd1, 32'd1, 32'd2, 32'd3, 32'd5, 32'd8, 32'd13,
		32'd21, 32'd34, 32'd55, 32'd89, 32'd144, 32'd233, 32'd377, 32'd610,
		32'd987, 32'd1597, 32'd2584, 32'd4181, 32'd6765, 32'd10946, 32'd17711, 32'd28657,
		32'd46368, 32'd75025, 32'd121393, 32'd196418, 32'd317811, 32'd514229,
		32'd832040, 32'd1346269
	};

	typedef enum logic [1:0] {
		ACC_NONE  = 2'd0,
		ACC_PROBE = 2'd1,
		ACC_FINAL = 2'd2
	} acc_mode_t;

	typedef struct packed {
		acc_mode_t mode;
		addr_t     addr;
	} access_t;

	// table port request from the sequencer
	typedef struct packed {
		logic   wr_en;
		addr_t  wr_addr;
		value_t wr_data;
		addr_t  rd_addr;
	} mem_req_t;

	// next table access for a fibonacci index k and offset+1
	function automatic access_t next_access(input fib_idx_t k, input count_t off1,
		input count_t n);
		access_t        a;
		logic [CNT_W:0] s;
		fib_idx_t       km2;
		km2    = k - FIB_IDX_W'(2);
		s      = {1'b0, off1} + FIB_TAB[km2][CNT_W:0];
		a.mode = ACC_NONE;
		a.addr = '0;
		if (k >= FIB_IDX_W'(3)) begin
			a.mode = ACC_PROBE;
			if (s > {1'b0, n}) begin
				a.addr = ADDR_W'(n - CNT_W'(1));
			end else begin
				a.addr = ADDR_W'(s - (CNT_W+1)'(1));
			end
		end else if (k != FIB_IDX_W'(1) && off1 < n) begin
			a.mode = ACC_FINAL;
			a.addr = ADDR_W'(off1);
		end
		return a;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/fts_if.sv
// channel interfaces: configuration, command requests and search results
`default_nettype none
interface fts_cfg_if;
	import fts_pkg::*;
	logic   valid;
	logic   ready;
	count_t entry_count;
	modport source (output valid, output entry_count, input ready);
	modport sink (input valid, input entry_count, output ready);
endinterface

interface fts_cmd_if;
	import fts_pkg::*;
	logic   valid;
	logic   ready;
	logic   command;
	addr_t  entry_index;
	value_t entry_value;
	value_t search_key;
	modport source (output valid, output command, output entry_index, output entry_value,
		output search_key, input ready);
	modport sink (input valid, input command, input entry_index, input entry_value,
		input search_key, output ready);
endinterface

interface fts_res_if;
	import fts_pkg::*;
	logic  valid;
	logic  ready;
	logic  found;
	addr_t found_index;
	modport source (output valid, output found, output found_index, input ready);
	modport sink (input valid, input found, input found_index, output ready);
endinterface
`default_nettype wire

>>> rtl/core/fts_table_mem.sv
// value table: one write port, one registered read port
`default_nettype none
module fts_table_mem (
	input  wire logic              clk,
	input  wire fts_pkg::mem_req_t req,
	output fts_pkg::value_t        rd_data_q
);
	import fts_pkg::*;

	value_t mem_q [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		rd_data_q <= mem_q[req.rd_addr];
	end

endmodule
`default_nettype wire

>>> rtl/core/fts_search_ctrl.sv
// search sequencer: count register, probe steps, final check and result register
`default_nettype none
module fts_search_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	fts_cfg_if.sink                cfg,
	fts_cmd_if.sink                cmd,
	fts_res_if.source              result,
	output fts_pkg::mem_req_t      mem_req,
	input  wire fts_pkg::value_t   rd_data
);
	import fts_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_PROBE  = 4'b0010,
		ST_FINAL  = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	state_t   state_q, state_d;
	count_t   count_q;
	value_t   key_q;
	fib_idx_t k_q, k_d, k0;
	count_t   off1_q, off1_d;
	addr_t    idx_q;
	logic     res_found_q, res_found_d;
	addr_t    res_index_q, res_index_d;
	logic     out_valid_q;
	logic     out_found_q;
	addr_t    out_index_q;

	access_t  acc_start, acc_lt, acc_gt, acc;
	logic     acc_take;
	logic     cmd_take, out_load;
	logic     hit, less;

	assign cfg.ready = 1'b1;
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_take  = cmd.valid && cmd.ready;
	assign out_load  = (state_q == ST_RESULT) && (!out_valid_q || result.ready);

	assign result.valid       = out_valid_q;
	assign result.found       = out_found_q;
	assign result.found_index = out_index_q;

	// smallest k >= 2 with F(k) >= count
	always_comb begin
		k0 = FIB_IDX_W'(2);
		for (int i = FIB_N - 1; i >= 2; i--) begin
			if (FIB_TAB[i] >= 32'(count_q)) begin
				k0 = FIB_IDX_W'(i);
			end
		end
	end

	assign acc_start = next_access(k0, '0, count_q);
	// both follow-up probes are prepared before the compare settles
	assign acc_lt    = next_access(k_q - FIB_IDX_W'(1), count_t'(idx_q) + count_t'(1), count_q);
	assign acc_gt    = next_access(k_q - FIB_IDX_W'(2), off1_q, count_q);
	assign hit       = (rd_data == key_q);
	assign less      = (rd_data < key_q);

	always_comb begin
		state_d     = state_q;
		k_d         = k_q;
		off1_d      = off1_q;
		res_found_d = res_found_q;
		res_index_d = res_index_q;
		acc         = acc_start;
		acc_take    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_take && cmd.command == CMD_SEARCH) begin
					acc      = acc_start;
					acc_take = 1'b1;
					k_d      = k0;
					off1_d   = '0;
				end
			end
			ST_PROBE: begin
				if (hit) begin
					res_found_d = 1'b1;
					res_index_d = idx_q;
					state_d     = ST_RESULT;
				end else if (less) begin
					acc      = acc_lt;
					acc_take = 1'b1;
					k_d      = k_q - FIB_IDX_W'(1);
					off1_d   = count_t'(idx_q) + count_t'(1);
				end else begin
					acc      = acc_gt;
					acc_take = 1'b1;
					k_d      = k_q - FIB_IDX_W'(2);
				end
			end
			ST_FINAL: begin
				res_found_d = hit;
				res_index_d = hit ? idx_q : '0;
				state_d     = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (acc_take) begin
			unique case (acc.mode)
				ACC_PROBE: state_d = ST_PROBE;
				ACC_FINAL: state_d = ST_FINAL;
				ACC_NONE: begin
					res_found_d = 1'b0;
					res_index_d = '0;
					state_d     = ST_RESULT;
				end
				default: state_d = ST_IDLE;
			endcase
		end
	end

	always_comb begin
		mem_req.wr_en   = cmd_take && cmd.command == CMD_WRITE;
		mem_req.wr_addr = cmd.entry_index;
		mem_req.wr_data = cmd.entry_value;
		mem_req.rd_addr = acc.addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				count_q <= (cfg.entry_count > count_t'(TABLE_DEPTH)) ?
					count_t'(TABLE_DEPTH) : cfg.entry_count;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			key_q <= cmd.search_key;
		end
		if (acc_take) begin
			idx_q <= acc.addr;
		end
		k_q         <= k_d;
		off1_q      <= off1_d;
		res_found_q <= res_found_d;
		res_index_q <= res_index_d;
		if (out_load) begin
			out_found_q <= res_found_q;
			out_index_q <= res_index_q;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/fibonacci_table_search_core.sv
// top level of the fibonacci table search block
// usage:
//   cfg    - write channel for the entry count (values above the table depth
//            saturate to the depth); always ready, write only while idle
//   cmd    - request channel; a write request stores entry_value at
//            entry_index and gives no result, a search request looks up
//            search_key among entries 0 .. count-1 and gives one result
//   result - found flag and matching index (index 0 when not found)
// sequence:
//   a write request leaves the sequencer idle; the next request is taken right after
//   a search makes one probe per cycle (one table read, one compare), at most
//   15 for 1024 entries, then at most one final check; the outcome goes into
//   the result register and from there into the output register, and the
//   next request is taken once the output register has been loaded
// reset:
//   arst_n clears the count to zero and the sequencer to idle; table
//   contents are kept undefined until written
// stalls:
//   a held result stays in the output register; requests are still taken, but
//   the next search then waits with its result until that register frees
`default_nettype none
module fibonacci_table_search_core (
	input wire logic clk,
	input wire logic arst_n,
	fts_cfg_if.sink   cfg,
	fts_cmd_if.sink   cmd,
	fts_res_if.source result
);
	import fts_pkg::*;

	mem_req_t mem_req;
	value_t   rd_data;

	// sequencer owns the count register, the probe loop and the result register
	fts_search_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.cmd     (cmd),
		.result  (result),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	// single table memory, read data is registered and arrives in the cycle after the address
	fts_table_mem u_mem (
		.clk       (clk),
		.req       (mem_req),
		.rd_data_q (rd_data)
	);

endmodule
`default_nettype wire

>>> rtl/core/fts_checker.sv
// port-level checks of the fibonacci table search block and their binding
`default_nettype none
module fts_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         cmd_valid,
	input wire logic         cmd_ready,
	input wire logic         cmd_command,
	input wire logic         res_valid,
	input wire logic         res_ready,
	input wire logic         res_found,
	input wire fts_pkg::addr_t res_index
);
	import fts_pkg::*;

	logic [1:0] pending_q;
	logic       search_take, res_take;

	assign search_take = cmd_valid && cmd_ready && cmd_command == CMD_SEARCH;
	assign res_take    = res_valid && res_ready;

	// searches taken whose result has not been delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (search_take && !res_take) begin
			pending_q <= pending_q + 2'd1;
		end else if (res_take && !search_take) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_found) && $stable(res_index))
		else $error("result changed while stalled");

	a_miss_index: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_found |-> res_index == '0)
		else $error("nonzero index on a miss");

	a_res_needs_search: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pending_q != 2'd0)
		else $error("result without a search");

	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("too many searches in flight");

endmodule

bind fibonacci_table_search_core fts_checker u_fts_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.cmd_command (cmd.command),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.res_found   (result.found),
	.res_index   (result.found_index)
);
`default_nettype wire
